[hw/rtl/ieu_pkg.sv]
// shared types and constants for the interpreter execute unit
// no dependencies
package ieu_pkg;

  localparam int unsigned OP_W   = 5;
  localparam int unsigned REG_W  = 4;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned ADDR_W = 12;
  localparam int unsigned STAT_W = 2;

  localparam logic [ADDR_W-1:0] FONT_BASE_RESET = 12'h050;
  localparam logic [ADDR_W-1:0] PC_RESET        = 12'h200;
  localparam logic [REG_W-1:0]  FLAG_REG        = 4'hF;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd2;

  localparam logic [OP_W-1:0] OP_RET   = 5'd0;
  localparam logic [OP_W-1:0] OP_JP    = 5'd1;
  localparam logic [OP_W-1:0] OP_CALL  = 5'd2;
  localparam logic [OP_W-1:0] OP_SE_K  = 5'd3;
  localparam logic [OP_W-1:0] OP_SNE_K = 5'd4;
  localparam logic [OP_W-1:0] OP_SE_R  = 5'd5;
  localparam logic [OP_W-1:0] OP_LD_K  = 5'd6;
  localparam logic [OP_W-1:0] OP_ADD_K = 5'd7;
  localparam logic [OP_W-1:0] OP_LD_R  = 5'd8;
  localparam logic [OP_W-1:0] OP_OR    = 5'd9;
  localparam logic [OP_W-1:0] OP_AND   = 5'd10;
  localparam logic [OP_W-1:0] OP_XOR   = 5'd11;
  localparam logic [OP_W-1:0] OP_ADD_R = 5'd12;
  localparam logic [OP_W-1:0] OP_SUB   = 5'd13;
  localparam logic [OP_W-1:0] OP_SHR   = 5'd14;
  localparam logic [OP_W-1:0] OP_SUBN  = 5'd15;
  localparam logic [OP_W-1:0] OP_SHL   = 5'd16;
  localparam logic [OP_W-1:0] OP_SNE_R = 5'd17;
  localparam logic [OP_W-1:0] OP_LD_I  = 5'd18;
  localparam logic [OP_W-1:0] OP_JP_V0 = 5'd19;
  localparam logic [OP_W-1:0] OP_RND   = 5'd20;
  localparam logic [OP_W-1:0] OP_LD_DT = 5'd21;
  localparam logic [OP_W-1:0] OP_SET_DT= 5'd22;
  localparam logic [OP_W-1:0] OP_SET_ST= 5'd23;
  localparam logic [OP_W-1:0] OP_ADD_I = 5'd24;
  localparam logic [OP_W-1:0] OP_FONT  = 5'd25;
  localparam logic [OP_W-1:0] OP_BCD   = 5'd26;
  localparam logic [OP_W-1:0] OP_STORE = 5'd27;
  localparam logic [OP_W-1:0] OP_LOAD  = 5'd28;
  localparam logic [OP_W-1:0] OP_TICK  = 5'd29;
  localparam logic [OP_W-1:0] OP_POKE  = 5'd30;

  // instruction class chosen by the front end
  typedef enum logic [1:0] {
    CL_SIMPLE,  // completes in the idle state, no memory sequence
    CL_BCD,     // three memory writes
    CL_STORE,   // block store, one byte per cycle
    CL_LOAD     // block load, each byte read and then written to a register
  } iclass_t;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    iclass_t           iclass;
    logic [REG_W-1:0]  reg_x;
    logic [REG_W-1:0]  reg_y;
    logic [BYTE_W-1:0] imm_byte;
    logic [ADDR_W-1:0] imm_address;
    logic [BYTE_W-1:0] random_byte;
  } instr_t;

  typedef struct packed {
    logic [ADDR_W-1:0] next_pc;
    logic [ADDR_W-1:0] index_value;
    logic [STAT_W-1:0] status;
    logic              sound_on;
  } result_t;

endpackage

[hw/rtl/ieu_front.sv]
// front end: accepts instructions, classifies them, two-entry queue to the back end
// depends on ieu_pkg
module ieu_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  output logic            full,
  input  logic [4:0]      op,
  input  logic [3:0]      reg_x,
  input  logic [3:0]      reg_y,
  input  logic [7:0]      imm_byte,
  input  logic [11:0]     imm_address,
  input  logic [7:0]      random_byte,
  output logic            instr_valid,
  output ieu_pkg::instr_t instr,
  input  logic            instr_take
);
  import ieu_pkg::*;

  instr_t     slots [2];
  logic       rd_ptr;
  logic       wr_ptr;
  logic [1:0] count;
  instr_t     incoming;
  logic       do_push;
  logic       do_pop;

  always_comb begin
    incoming.op          = op;
    incoming.reg_x       = reg_x;
    incoming.reg_y       = reg_y;
    incoming.imm_byte    = imm_byte;
    incoming.imm_address = imm_address;
    incoming.random_byte = random_byte;
    case (op)
      OP_BCD:   incoming.iclass = CL_BCD;
      OP_STORE: incoming.iclass = CL_STORE;
      OP_LOAD:  incoming.iclass = CL_LOAD;
      default:  incoming.iclass = CL_SIMPLE;
    endcase
  end

  assign full        = (count == 2'd2);
  assign instr_valid = (count != 2'd0);
  assign instr       = slots[rd_ptr];
  assign do_push     = push && !full;
  assign do_pop      = instr_take && instr_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= incoming;
    end
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

[hw/rtl/ieu_back.sv]
// back end: architectural state, stack, memory and sequencer for multi-cycle ops
// depends on ieu_pkg
module ieu_back #(
  parameter int unsigned STACK_DEPTH  = 16,
  parameter int unsigned MEMORY_BYTES = 4096
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [11:0]             font_base,
  input  logic                    instr_valid,
  input  ieu_pkg::instr_t         instr,
  output logic                    instr_take,
  output logic                    res_valid,
  output ieu_pkg::result_t        res,
  input  logic                    res_take
);
  import ieu_pkg::*;

  localparam int unsigned SP_W  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned SI_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned MA_W  = $clog2(MEMORY_BYTES);

  typedef enum logic [1:0] {S_IDLE, S_MEM, S_LOADW} state_t;

  state_t            state;
  logic [7:0]        vregs [16];
  logic [11:0]       index_reg;
  logic [11:0]       pc;
  logic [11:0]       rstack [STACK_DEPTH];
  logic [SP_W-1:0]   sp;
  logic [7:0]        delay_t;
  logic [7:0]        sound_t;
  logic [7:0]        mem [MEMORY_BYTES];
  logic [7:0]        mem_rd;
  instr_t            cur;
  logic [3:0]        step;
  logic [7:0]        bcd_d [3];
  logic [11:0]       ret_rd;
  logic [STAT_W-1:0] status_q;

  // combinational decode of the simple op
  logic [7:0]  vx, vy;
  logic [8:0]  sum9;
  logic [11:0] pc2, pc4;
  logic        stack_full, stack_empty;
  logic [7:0]  hund, tens, ones, rem;
  logic        start;
  logic [11:0] mem_a12;
  logic [MA_W-1:0] mem_a;

  // fold a 12-bit address into the memory by compare and subtract
  function automatic logic [MA_W-1:0] wrap_addr(logic [11:0] a);
    logic [14:0] t;
    t = {3'd0, a};
    for (int s = 2; s >= 0; s--) begin
      if (t >= 15'(MEMORY_BYTES << s)) t = t - 15'(MEMORY_BYTES << s);
    end
    return MA_W'(t);
  endfunction

  assign vx          = vregs[instr.reg_x];
  assign vy          = vregs[instr.reg_y];
  assign sum9        = {1'b0, vx} + {1'b0, vy};
  assign pc2         = pc + 12'd2;
  assign pc4         = pc + 12'd4;
  assign stack_full  = (sp >= SP_W'(STACK_DEPTH));
  assign stack_empty = (sp == '0);
  assign ret_rd      = rstack[SI_W'(sp - SP_W'(1))];
  assign start       = instr_valid && !res_valid && (state == S_IDLE);
  assign instr_take  = start;
  assign mem_a12     = index_reg + {8'd0, step};
  assign mem_a       = wrap_addr(mem_a12);

  // decimal digits: hundreds by compare and subtract, tens by multiply by 205 and shift
  always_comb begin
    hund = (vx >= 8'd200) ? 8'd2 : (vx >= 8'd100) ? 8'd1 : 8'd0;
    rem  = vx - ((vx >= 8'd200) ? 8'd200 : (vx >= 8'd100) ? 8'd100 : 8'd0);
    tens = 8'(({8'd0, rem} * 16'd205) >> 11);
    ones = rem - 8'(tens * 8'd10);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
      index_reg <= '0;
      pc        <= PC_RESET;
      sp        <= '0;
      delay_t   <= '0;
      sound_t   <= '0;
      step      <= '0;
      status_q  <= ST_OK;
      for (int i = 0; i < 16; i++) vregs[i] <= '0;
    end else begin
      if (res_valid && res_take) res_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            cur  <= instr;
            step <= '0;
            status_q <= ST_OK;
            if (instr.op <= OP_LOAD) pc <= pc2;
            case (instr.op)
              OP_RET: begin
                if (stack_empty) status_q <= ST_UNDERFLOW;
                else begin
                  sp <= sp - SP_W'(1);
                  pc <= ret_rd;
                end
              end
              OP_JP:  pc <= instr.imm_address;
              OP_CALL: begin
                if (stack_full) status_q <= ST_OVERFLOW;
                else begin
                  rstack[SI_W'(sp)] <= pc2;
                  sp <= sp + SP_W'(1);
                  pc <= instr.imm_address;
                end
              end
              OP_SE_K:  if (vx == instr.imm_byte) pc <= pc4;
              OP_SNE_K: if (vx != instr.imm_byte) pc <= pc4;
              OP_SE_R:  if (vx == vy) pc <= pc4;
              OP_SNE_R: if (vx != vy) pc <= pc4;
              OP_LD_K:  vregs[instr.reg_x] <= instr.imm_byte;
              OP_ADD_K: vregs[instr.reg_x] <= vx + instr.imm_byte;
              OP_LD_R:  vregs[instr.reg_x] <= vy;
              OP_OR:    vregs[instr.reg_x] <= vx | vy;
              OP_AND:   vregs[instr.reg_x] <= vx & vy;
              OP_XOR:   vregs[instr.reg_x] <= vx ^ vy;
              // flag write comes last so it wins when x is the flag register
              OP_ADD_R: begin
                vregs[instr.reg_x] <= sum9[7:0];
                vregs[FLAG_REG]    <= {7'd0, sum9[8]};
              end
              OP_SUB: begin
                vregs[instr.reg_x] <= vx - vy;
                vregs[FLAG_REG]    <= {7'd0, vx > vy};
              end
              OP_SHR: begin
                vregs[instr.reg_x] <= {1'b0, vx[7:1]};
                vregs[FLAG_REG]    <= {7'd0, vx[0]};
              end
              OP_SUBN: begin
                vregs[instr.reg_x] <= vy - vx;
                vregs[FLAG_REG]    <= {7'd0, vy > vx};
              end
              OP_SHL: begin
                vregs[instr.reg_x] <= {vx[6:0], 1'b0};
                vregs[FLAG_REG]    <= {7'd0, vx[7]};
              end
              OP_LD_I:   index_reg <= instr.imm_address;
              OP_JP_V0:  pc <= instr.imm_address + {4'd0, vregs[0]};
              OP_RND:    vregs[instr.reg_x] <= instr.imm_byte & instr.random_byte;
              OP_LD_DT:  vregs[instr.reg_x] <= delay_t;
              OP_SET_DT: delay_t <= vx;
              OP_SET_ST: sound_t <= vx;
              OP_ADD_I:  index_reg <= index_reg + {4'd0, vx};
              OP_FONT:   index_reg <= font_base + {2'd0, vx, 2'd0} + {4'd0, vx};
              OP_BCD: begin
                bcd_d[0] <= hund;
                bcd_d[1] <= tens;
                bcd_d[2] <= ones;
              end
              OP_TICK: begin
                if (delay_t != 8'd0) delay_t <= delay_t - 8'd1;
                if (sound_t != 8'd0) sound_t <= sound_t - 8'd1;
              end
              OP_POKE: mem[wrap_addr(instr.imm_address)] <= instr.imm_byte;
              default: ;
            endcase
            if (instr.iclass == CL_SIMPLE) res_valid <= 1'b1;
            else state <= S_MEM;
          end
        end
        S_MEM: begin
          // bcd and store write one memory byte per cycle; load reads one byte, then S_LOADW
          case (cur.iclass)
            CL_BCD: begin
              mem[mem_a] <= bcd_d[step[1:0]];
              if (step == 4'd2) begin
                state <= S_IDLE;
                res_valid <= 1'b1;
              end
              step <= step + 4'd1;
            end
            CL_STORE: begin
              mem[mem_a] <= vregs[step];
              if (step == cur.reg_x) begin
                state <= S_IDLE;
                res_valid <= 1'b1;
              end
              step <= step + 4'd1;
            end
            default: begin
              mem_rd <= mem[mem_a];
              state  <= S_LOADW;
            end
          endcase
        end
        S_LOADW: begin
          vregs[step] <= mem_rd;
          if (step == cur.reg_x) begin
            state <= S_IDLE;
            res_valid <= 1'b1;
          end else state <= S_MEM;
          step <= step + 4'd1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign res.next_pc     = pc;
  assign res.index_value = index_reg;
  assign res.status      = status_q;
  assign res.sound_on    = (sound_t != 8'd0);

endmodule

[hw/rtl/interpreter_execute_unit_core.sv]
// top level of the interpreter execute unit: front queue, back end, font base register
// depends on ieu_pkg, ieu_front, ieu_back
//
// channel | signals                                  | transaction when
// --------+------------------------------------------+-----------------------
// input   | push, full, op, reg_x, reg_y, imm_byte,  | push && !full
//         | imm_address, random_byte                 |
// result  | empty, pop, next_pc, index_value,        | pop && !empty
//         | status, sound_on                         |
// config  | cfg_valid, cfg_ready, cfg_data           | cfg_valid && cfg_ready
//
// simple ops finish in the back end idle state, bcd writes three digits, block store
// writes V0..Vx, block load alternates a memory read and a register write per byte
// (single memory port, registered read); a two entry queue in front lets new instructions arrive while one executes
// rst is synchronous: registers zero, pc 0x200, font base 0x50, stack empty
// a waiting result holds the back end; the front queue still fills
module interpreter_execute_unit_core #(
  parameter int unsigned STACK_DEPTH  = 16,
  parameter int unsigned MEMORY_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [4:0]  op,
  input  logic [3:0]  reg_x,
  input  logic [3:0]  reg_y,
  input  logic [7:0]  imm_byte,
  input  logic [11:0] imm_address,
  input  logic [7:0]  random_byte,
  output logic        empty,
  input  logic        pop,
  output logic [11:0] next_pc,
  output logic [11:0] index_value,
  output logic [1:0]  status,
  output logic        sound_on,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [11:0] cfg_data
);
  import ieu_pkg::*;

  logic        instr_valid;
  instr_t      instr;
  logic        instr_take;
  logic        res_valid;
  result_t     res;
  logic [11:0] font_base;

  // config is always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) font_base <= FONT_BASE_RESET;
    else if (cfg_valid && cfg_ready) font_base <= cfg_data;
  end

  ieu_front u_front (
    .clk, .rst, .push, .full, .op, .reg_x, .reg_y, .imm_byte, .imm_address,
    .random_byte, .instr_valid, .instr, .instr_take
  );

  ieu_back #(.STACK_DEPTH(STACK_DEPTH), .MEMORY_BYTES(MEMORY_BYTES)) u_back (
    .clk, .rst, .font_base, .instr_valid, .instr, .instr_take,
    .res_valid, .res, .res_take(pop)
  );

  assign empty       = !res_valid;
  assign next_pc     = res.next_pc;
  assign index_value = res.index_value;
  assign status      = res.status;
  assign sound_on    = res.sound_on;

  // result register only clears on a pop
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> !empty)
    else $error("result dropped without pop");

  // status code stays in range
  a_status: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (status != 2'd3))
    else $error("bad status");

  // back end takes nothing while a result waits
  a_take: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !instr_take)
    else $error("instruction taken over pending result");

endmodule
